### rtl/core/trlt_pkg.sv
`default_nettype none
package trlt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ID_BITS = 16;
   localparam int STAMP_BITS = 38;
   localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_RETRIEVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REPLACED = 2'd1,
      ST_DROPPED  = 2'd2
   } status_type;

   localparam logic [2:0] G_YEAR = 3'd0;
   localparam logic [2:0] G_MONTH = 3'd1;
   localparam logic [2:0] G_DAY = 3'd2;
   localparam logic [2:0] G_HOUR = 3'd3;
   localparam logic [2:0] G_MINUTE = 3'd4;

   localparam logic [STAMP_BITS-1:0] LOW_FILL = (38'd1 << 22) | (38'd1 << 17);
   localparam logic [STAMP_BITS-1:0] HIGH_FILL = (38'd12 << 22) | (38'd31 << 17)
      | (38'd23 << 12) | (38'd59 << 6) | 38'd59;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      logic                  op;
      logic [ID_BITS-1:0]    id;
      logic [STAMP_BITS-1:0] lo;
      logic [STAMP_BITS-1:0] hi;
   } cmd_type;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic               matched;
      logic               last;
      status_type         status;
   } rsp_type;

   function automatic logic [STAMP_BITS-1:0] keep_mask(input logic [2:0] g);
      logic [STAMP_BITS-1:0] m;
      case (g)
         G_YEAR:   m = 38'h3FFC000000;
         G_MONTH:  m = 38'h3FFFC00000;
         G_DAY:    m = 38'h3FFFFE0000;
         G_HOUR:   m = 38'h3FFFFFF000;
         G_MINUTE: m = 38'h3FFFFFFFC0;
         default:  m = 38'h3FFFFFFFFF;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

### rtl/core/timestamp_range_log_table.sv
// Channel      Ports                                           Direction
// request      req_push req_full req_cmd req_entry_id          in
//              req_start_time req_end_time req_granularity
// response     rsp_pop rsp_empty rsp_result_id rsp_matched     out
//              rsp_last rsp_status
//
// A store is written into the table when it is taken from the head of the command queue.
// A retrieve with no match pushes a single no-match response; otherwise it loads its
// match vector into the scan chain, which then shifts through the stored entries up to
// the last match, pushing one response per match.
// Reset clears the entry count and both queues; table contents need no clearing.
// A full response queue stalls the table, and a full command queue raises req_full.
`default_nettype none
module timestamp_range_log_table (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic                            req_cmd,
   input  wire logic [trlt_pkg::ID_BITS-1:0]    req_entry_id,
   input  wire logic [trlt_pkg::STAMP_BITS-1:0] req_start_time,
   input  wire logic [trlt_pkg::STAMP_BITS-1:0] req_end_time,
   input  wire logic [2:0]                      req_granularity,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [trlt_pkg::ID_BITS-1:0]         rsp_result_id,
   output logic                                 rsp_matched,
   output logic                                 rsp_last,
   output logic [1:0]                           rsp_status
);
   import trlt_pkg::*;

   logic    cmd_valid, cmd_take;
   cmd_type cmd_head;

   trlt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_entry_id   (req_entry_id),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .req_granularity(req_granularity),
      .cmd_valid      (cmd_valid),
      .cmd_head       (cmd_head),
      .cmd_take       (cmd_take)
   );

   trlt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_head     (cmd_head),
      .cmd_take     (cmd_take),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_result_id(rsp_result_id),
      .rsp_matched  (rsp_matched),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status)
   );

endmodule
`default_nettype wire

### rtl/core/trlt_front.sv
`default_nettype none
module trlt_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_cmd,
   input  wire logic [trlt_pkg::ID_BITS-1:0]   req_entry_id,
   input  wire logic [trlt_pkg::STAMP_BITS-1:0] req_start_time,
   input  wire logic [trlt_pkg::STAMP_BITS-1:0] req_end_time,
   input  wire logic [2:0]                     req_granularity,
   output logic                                cmd_valid,
   output trlt_pkg::cmd_type                   cmd_head,
   input  wire logic                           cmd_take
);
   import trlt_pkg::*;

   cmd_type          q_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   cmd_type          entry;
   logic [STAMP_BITS-1:0] km;
   logic             do_push, do_pop;

   always_comb begin
      km = keep_mask(req_granularity);
      entry.op = req_cmd;
      entry.id = req_entry_id;
      if (req_cmd == CMD_STORE) begin
         entry.lo = req_start_time;
         entry.hi = req_end_time;
      end else begin
         entry.lo = (req_start_time & km) | (LOW_FILL & ~km);
         entry.hi = (req_end_time & km) | (HIGH_FILL & ~km);
      end
      req_full = (cnt_ff == 2'd2);
      cmd_valid = (cnt_ff != 2'd0);
      cmd_head = q_ff[rd_ff];
      do_push = req_push && !req_full;
      do_pop = cmd_take && cmd_valid;
      wr_in = wr_ff ^ do_push;
      rd_in = rd_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ff] <= entry;
      end
   end

endmodule
`default_nettype wire

### rtl/core/trlt_back.sv
`default_nettype none
module trlt_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         cmd_valid,
   input  wire trlt_pkg::cmd_type            cmd_head,
   output logic                              cmd_take,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic [trlt_pkg::ID_BITS-1:0]      rsp_result_id,
   output logic                              rsp_matched,
   output logic                              rsp_last,
   output logic [1:0]                        rsp_status
);
   import trlt_pkg::*;

   logic [STAMP_BITS-1:0] key_ff [TABLE_DEPTH];
   logic [STAMP_BITS-1:0] key_in [TABLE_DEPTH];
   logic [ID_BITS-1:0]    id_ff [TABLE_DEPTH];
   logic [ID_BITS-1:0]    id_in [TABLE_DEPTH];
   logic [ID_BITS-1:0]    sid_ff [TABLE_DEPTH];
   logic [ID_BITS-1:0]    sid_in [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] sm_ff, sm_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   back_state_type        state_ff, state_in;

   logic [TABLE_DEPTH-1:0] valid, lt, eq, hit;
   logic                  key_write, id_write, scan_load;

   rsp_type               oq_ff [2];
   logic                  owr_ff, owr_in, ord_ff, ord_in;
   logic [1:0]            ocnt_ff, ocnt_in;
   logic                  o_push, o_pop, o_space;
   rsp_type               o_data;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         valid[i] = (COUNT_BITS'(i) < count_ff);
         lt[i] = valid[i] && (key_ff[i] < cmd_head.lo);
         eq[i] = valid[i] && (key_ff[i] == cmd_head.lo);
         hit[i] = valid[i] && (key_ff[i] >= cmd_head.lo) && (key_ff[i] <= cmd_head.hi);
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sm_in = sm_ff;
      cmd_take = 1'b0;
      o_push = 1'b0;
      o_data = '{id: '0, matched: 1'b0, last: 1'b1, status: ST_OK};
      key_write = 1'b0;
      id_write = 1'b0;
      scan_load = 1'b0;
      o_space = (ocnt_ff != 2'd2);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         key_in[i] = key_ff[i];
         id_in[i] = id_ff[i];
         sid_in[i] = sid_ff[i];
      end
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && o_space) begin
               cmd_take = 1'b1;
               if (cmd_head.op == CMD_STORE) begin
                  o_push = 1'b1;
                  if (|eq) begin
                     o_data.status = ST_REPLACED;
                     id_write = 1'b1;
                     for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (eq[i]) begin
                           id_in[i] = cmd_head.id;
                        end
                     end
                  end else if (count_ff == COUNT_BITS'(TABLE_DEPTH)) begin
                     o_data.status = ST_DROPPED;
                  end else begin
                     key_write = 1'b1;
                     id_write = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (!lt[0]) begin
                        key_in[0] = cmd_head.lo;
                        id_in[0] = cmd_head.id;
                     end
                     for (int i = 1; i < TABLE_DEPTH; i++) begin
                        if (!lt[i]) begin
                           if (lt[i - 1]) begin
                              key_in[i] = cmd_head.lo;
                              id_in[i] = cmd_head.id;
                           end else begin
                              key_in[i] = key_ff[i - 1];
                              id_in[i] = id_ff[i - 1];
                           end
                        end
                     end
                  end
               end else if (|hit) begin
                  scan_load = 1'b1;
                  sm_in = hit;
                  state_in = BK_SCAN;
               end else begin
                  o_push = 1'b1;
               end
            end
         end
         BK_SCAN: begin
            if (o_space) begin
               sm_in = {1'b0, sm_ff[TABLE_DEPTH-1:1]};
               for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                  sid_in[i] = sid_ff[i + 1];
               end
               if (sm_ff[0]) begin
                  o_push = 1'b1;
                  o_data.id = sid_ff[0];
                  o_data.matched = 1'b1;
                  o_data.last = ~|sm_ff[TABLE_DEPTH-1:1];
                  if (o_data.last) begin
                     state_in = BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (scan_load) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            sid_in[i] = id_ff[i];
         end
      end
   end

   always_comb begin
      rsp_empty = (ocnt_ff == 2'd0);
      rsp_result_id = oq_ff[ord_ff].id;
      rsp_matched = oq_ff[ord_ff].matched;
      rsp_last = oq_ff[ord_ff].last;
      rsp_status = oq_ff[ord_ff].status;
      o_pop = rsp_pop && !rsp_empty;
      owr_in = owr_ff ^ o_push;
      ord_in = ord_ff ^ o_pop;
      ocnt_in = ocnt_ff + {1'b0, o_push} - {1'b0, o_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         sm_ff <= '0;
         owr_ff <= 1'b0;
         ord_ff <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sm_ff <= sm_in;
         owr_ff <= owr_in;
         ord_ff <= ord_in;
         ocnt_ff <= ocnt_in;
      end
      if (o_push) begin
         oq_ff[owr_ff] <= o_data;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (key_write) begin
            key_ff[i] <= key_in[i];
         end
         if (id_write) begin
            id_ff[i] <= id_in[i];
         end
         sid_ff[i] <= sid_in[i];
      end
   end

endmodule
`default_nettype wire

### verif/trlt_checker.sv
`default_nettype none
module trlt_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   input  wire logic                            req_full,
   input  wire logic                            req_cmd,
   input  wire logic [trlt_pkg::ID_BITS-1:0]    req_entry_id,
   input  wire logic [trlt_pkg::STAMP_BITS-1:0] req_start_time,
   input  wire logic [trlt_pkg::STAMP_BITS-1:0] req_end_time,
   input  wire logic [2:0]                      req_granularity,
   input  wire logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   input  wire logic [trlt_pkg::ID_BITS-1:0]    rsp_result_id,
   input  wire logic                            rsp_matched,
   input  wire logic                            rsp_last,
   input  wire logic [1:0]                      rsp_status,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   match_count
);
   import trlt_pkg::*;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic               matched;
      logic               last;
      logic [1:0]         status;
   } answer_type;

   logic [STAMP_BITS-1:0] stamp_table [TABLE_DEPTH];
   logic [ID_BITS-1:0]    id_table [TABLE_DEPTH];
   int                    entries;
   answer_type            answers [$];

   function automatic answer_type make_answer(logic [ID_BITS-1:0] id, logic m, logic l,
                                              status_type s);
      answer_type a;
      a.id = id;
      a.matched = m;
      a.last = l;
      a.status = s;
      return a;
   endfunction

   task automatic queue_answer(answer_type a);
      answers = {answers, a};
   endtask

   task automatic apply_store(logic [ID_BITS-1:0] id, logic [STAMP_BITS-1:0] stamp);
      int pos;
      pos = 0;
      while (pos < entries && stamp_table[pos] < stamp) pos++;
      if (pos < entries && stamp_table[pos] == stamp) begin
         id_table[pos] = id;
         queue_answer(make_answer('0, 1'b0, 1'b1, ST_REPLACED));
      end else if (entries >= TABLE_DEPTH) begin
         queue_answer(make_answer('0, 1'b0, 1'b1, ST_DROPPED));
      end else begin
         for (int i = entries; i > pos; i--) begin
            stamp_table[i] = stamp_table[i-1];
            id_table[i] = id_table[i-1];
         end
         stamp_table[pos] = stamp;
         id_table[pos] = id;
         entries++;
         queue_answer(make_answer('0, 1'b0, 1'b1, ST_OK));
      end
   endtask

   task automatic apply_range(logic [STAMP_BITS-1:0] t0, logic [STAMP_BITS-1:0] t1,
                              logic [2:0] g);
      logic [STAMP_BITS-1:0] mask;
      logic [STAMP_BITS-1:0] lo;
      logic [STAMP_BITS-1:0] hi;
      logic [STAMP_BITS-1:0] low_pad;
      logic [STAMP_BITS-1:0] high_pad;
      int hits;
      low_pad = {12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
      high_pad = {12'd0, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};
      case (g)
         G_YEAR:   mask = {{12{1'b1}}, 26'd0};
         G_MONTH:  mask = {{16{1'b1}}, 22'd0};
         G_DAY:    mask = {{21{1'b1}}, 17'd0};
         G_HOUR:   mask = {{26{1'b1}}, 12'd0};
         G_MINUTE: mask = {{32{1'b1}}, 6'd0};
         default:  mask = '1;
      endcase
      lo = (t0 & mask) | (low_pad & ~mask);
      hi = (t1 & mask) | (high_pad & ~mask);
      hits = 0;
      for (int i = 0; i < entries; i++) begin
         if (stamp_table[i] >= lo && stamp_table[i] <= hi) begin
            queue_answer(make_answer(id_table[i], 1'b1, 1'b0, ST_OK));
            hits++;
         end
      end
      if (hits == 0) begin
         queue_answer(make_answer('0, 1'b0, 1'b1, ST_OK));
      end else begin
         answers[$].last = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         entries = 0;
         answers.delete();
         fail_count <= 0;
         match_count <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (answers.size() == 0) begin
               $display("%0t: unexpected transaction id=%h matched=%b last=%b status=%0d",
                        $time, rsp_result_id, rsp_matched, rsp_last, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (want != {rsp_result_id, rsp_matched, rsp_last, rsp_status}) begin
                  $display("%0t: mismatch expected id=%h matched=%b last=%b status=%0d",
                           $time, want.id, want.matched, want.last, want.status);
                  $display("%0t:          actual   id=%h matched=%b last=%b status=%0d",
                           $time, rsp_result_id, rsp_matched, rsp_last, rsp_status);
                  fail_count <= fail_count + 1;
               end
               if (rsp_matched) match_count <= match_count + 1;
            end
         end
         if (req_push && !req_full) begin
            if (req_cmd == CMD_STORE) apply_store(req_entry_id, req_start_time);
            else apply_range(req_start_time, req_end_time, req_granularity);
         end
      end
   end

   assign pending_count = answers.size();
endmodule
`default_nettype wire

### verif/tb_timestamp_range_log_table.sv
`default_nettype none
module tb_timestamp_range_log_table;
   import trlt_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic                  req_cmd;
   logic [ID_BITS-1:0]    req_entry_id;
   logic [STAMP_BITS-1:0] req_start_time;
   logic [STAMP_BITS-1:0] req_end_time;
   logic [2:0]            req_granularity;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [ID_BITS-1:0]    rsp_result_id;
   logic                  rsp_matched;
   logic                  rsp_last;
   logic [1:0]            rsp_status;
   int                    fail_count;
   int                    pending_count;
   int                    match_count;
   int                    sent;
   int                    idle_cycles;
   bit                    quiet_tail;
   bit                    hold_pop;
   logic [STAMP_BITS-1:0] used_stamps [$];

   timestamp_range_log_table u_top (.*);

   trlt_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [STAMP_BITS-1:0] make_stamp(bit narrow);
      logic [STAMP_BITS-1:0] s;
      if (narrow)
         s = {12'd2020 + 12'($urandom_range(0, 1)), 4'($urandom_range(1, 12)),
              5'($urandom_range(1, 3)), 5'($urandom_range(0, 23)),
              6'($urandom_range(0, 59)), 6'($urandom_range(0, 59))};
      else
         s = {6'($urandom), $urandom};
      return s;
   endfunction

   task automatic send(logic c, logic [ID_BITS-1:0] id, logic [STAMP_BITS-1:0] t0,
                       logic [STAMP_BITS-1:0] t1, logic [2:0] g);
      int gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_cmd <= c;
      req_entry_id <= id;
      req_start_time <= t0;
      req_end_time <= t1;
      req_granularity <= g;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent++;
   endtask

   task automatic drain;
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic store_random(bit narrow);
      logic [STAMP_BITS-1:0] s;
      if (used_stamps.size() != 0 && $urandom_range(0, 3) == 0)
         s = used_stamps[$urandom_range(0, used_stamps.size() - 1)];
      else
         s = make_stamp(narrow);
      used_stamps = {used_stamps, s};
      send(CMD_STORE, 16'($urandom), s, make_stamp(0), 3'($urandom));
   endtask

   task automatic range_random;
      logic [STAMP_BITS-1:0] a;
      logic [STAMP_BITS-1:0] b;
      a = make_stamp(1);
      b = make_stamp(1);
      if ($urandom_range(0, 5) != 0 && a > b) begin
         a = b ^ a;
         b = a ^ b;
         a = a ^ b;
      end
      if ($urandom_range(0, 9) == 0 && used_stamps.size() != 0) begin
         a = used_stamps[$urandom_range(0, used_stamps.size() - 1)];
         b = a;
      end
      send(CMD_RETRIEVE, 16'($urandom), a, b, 3'($urandom_range(0, 7)));
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_cmd = CMD_STORE;
      req_entry_id = '0;
      req_start_time = '0;
      req_end_time = '0;
      req_granularity = '0;
      sent = 0;
      quiet_tail = 1'b0;
      hold_pop = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(CMD_RETRIEVE, '0, '0, '1, 3'd5);
      send(CMD_STORE, 16'hFFFF, '1, '0, 3'd0);
      send(CMD_STORE, 16'h0000, '0, '1, 3'd7);
      send(CMD_STORE, 16'h1234, {12'd2021, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30}, '0, 3'd0);
      send(CMD_STORE, 16'h5678, {12'd2021, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30}, '0, 3'd0);
      send(CMD_STORE, 16'hAAAA, {12'd2021, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, '0, 3'd0);
      for (int g = 0; g < 8; g++)
         send(CMD_RETRIEVE, '0, {12'd2021, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30},
              {12'd2021, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30}, 3'(g));
      send(CMD_RETRIEVE, '0, {12'd2022, 26'd0}, {12'd2020, 26'd0}, G_YEAR);
      send(CMD_RETRIEVE, '0, '0, '1, 3'd6);
      drain();

      hold_pop = 1'b1;
      for (int k = 0; k < 70; k++) store_random(1);
      for (int k = 0; k < 6; k++) range_random();
      hold_pop = 1'b0;
      drain();
      send(CMD_STORE, 16'h0F0F, {12'd4000, 26'd0}, '0, 3'd0);
      send(CMD_STORE, 16'hF0F0, used_stamps[3], '0, 3'd0);
      send(CMD_RETRIEVE, '0, '0, '1, G_YEAR);
      for (int k = 0; k < 60; k++) range_random();
      drain();

      reset <= 1'b0;
      for (int k = 0; k < 160; k++) begin
         if (k == 120) quiet_tail = 1'b1;
         if ($urandom_range(0, 2) == 0) store_random($urandom_range(0, 3) != 0);
         else range_random();
      end
      drain();

      $display("Sent %0d transactions, including stores, overwrites, full-table drops,", sent);
      $display("and range queries at every granularity; %0d matching ids returned.",
               match_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int burst;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_pop) begin
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
            while (hold_pop) begin
               rsp_pop <= 1'b1;
               @(posedge clock);
            end
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_pop <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("Timeout with %0d transactions outstanding", pending_count);
            $display("Test completed with failures");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire
